@@ rtl/hmmu_pkg.sv @@
// ----------------------------------------------------------------------------
// hmmu_pkg
// Shared types, constants and address helpers of the handheld memory map unit.
// ----------------------------------------------------------------------------
package hmmu_pkg;

  // widths of the bus and depth of the byte store
  localparam int unsigned ADDR_W    = 16;
  localparam int unsigned DATA_W    = 8;
  localparam int unsigned MEM_DEPTH = 65536;

  // object copy length and its counter width
  localparam int unsigned DMA_LEN   = 160;
  localparam int unsigned DMA_CNT_W = (DMA_LEN > 1) ? $clog2(DMA_LEN) : 1;

  // access kinds carried on tuser
  localparam logic [1:0] FUNC_RD   = 2'd0;
  localparam logic [1:0] FUNC_WR   = 2'd1;
  localparam logic [1:0] FUNC_RD16 = 2'd2;

  // special addresses
  localparam logic [ADDR_W-1:0] ROM_END    = 16'h8000;
  localparam logic [ADDR_W-1:0] ECHO_BASE  = 16'hE000;
  localparam logic [ADDR_W-1:0] ECHO_LAST  = 16'hFDFF;
  localparam logic [ADDR_W-1:0] ECHO_OFS   = 16'h2000;
  localparam logic [ADDR_W-1:0] OAM_BASE   = 16'hFE00;
  localparam logic [ADDR_W-1:0] UNUSE_BASE = 16'hFEA0;
  localparam logic [ADDR_W-1:0] UNUSE_LAST = 16'hFEFF;
  localparam logic [ADDR_W-1:0] JOYP_ADDR  = 16'hFF00;
  localparam logic [ADDR_W-1:0] DIV_ADDR   = 16'hFF04;
  localparam logic [ADDR_W-1:0] IF_ADDR    = 16'hFF0F;
  localparam logic [ADDR_W-1:0] LY_ADDR    = 16'hFF44;
  localparam logic [ADDR_W-1:0] DMA_ADDR   = 16'hFF46;

  localparam logic [DATA_W-1:0] JOYP_WMASK = 8'hF0;
  localparam logic [DATA_W-1:0] JOYP_FORCE = 8'hC0;
  localparam logic [DATA_W-1:0] IF_FORCE   = 8'hE0;

  // sequencer states
  typedef enum logic [9:0] {
    S_CLR    = 10'b00_0000_0001,
    S_IDLE   = 10'b00_0000_0010,
    S_RD_LO  = 10'b00_0000_0100,
    S_CAP_LO = 10'b00_0000_1000,
    S_RD_HI  = 10'b00_0001_0000,
    S_CAP_HI = 10'b00_0010_0000,
    S_WR     = 10'b00_0100_0000,
    S_DMA_RD = 10'b00_1000_0000,
    S_DMA_WR = 10'b01_0000_0000,
    S_DONE   = 10'b10_0000_0000
  } state_e;

  // echo region folds onto work ram
  function automatic logic [ADDR_W-1:0] map_addr(input logic [ADDR_W-1:0] a);
    logic [ADDR_W-1:0] m;
    m = a;
    if (a inside {[ECHO_BASE:ECHO_LAST]}) begin
      m = a - ECHO_OFS;
    end
    return m;
  endfunction

  // bits forced high when reading a register
  function automatic logic [DATA_W-1:0] force_mask(input logic [ADDR_W-1:0] a);
    logic [DATA_W-1:0] f;
    f = '0;
    if (a == JOYP_ADDR) begin
      f = JOYP_FORCE;
    end else if (a == IF_ADDR) begin
      f = IF_FORCE;
    end
    return f;
  endfunction

  // power-up contents of the store
  function automatic logic [DATA_W-1:0] init_value(input logic [ADDR_W-1:0] a);
    logic [DATA_W-1:0] v;
    case (a)
      16'hFF00: v = 8'hFF;
      16'hFF10: v = 8'h80;
      16'hFF11: v = 8'hBF;
      16'hFF12: v = 8'hF3;
      16'hFF14: v = 8'hBF;
      16'hFF16: v = 8'h3F;
      16'hFF19: v = 8'hBF;
      16'hFF1A: v = 8'h7F;
      16'hFF1B: v = 8'hFF;
      16'hFF1C: v = 8'h9F;
      16'hFF1E: v = 8'hBF;
      16'hFF20: v = 8'hFF;
      16'hFF23: v = 8'hBF;
      16'hFF24: v = 8'h77;
      16'hFF25: v = 8'hF3;
      16'hFF26: v = 8'hF1;
      16'hFF40: v = 8'h91;
      16'hFF47: v = 8'hFC;
      16'hFF48: v = 8'hFF;
      16'hFF49: v = 8'hFF;
      default:  v = 8'h00;
    endcase
    return v;
  endfunction

endpackage

@@ rtl/hmmu_ram.sv @@
// ----------------------------------------------------------------------------
// hmmu_ram
// Generic simple dual-port ram: one write port, one registered read port.
// ----------------------------------------------------------------------------
module hmmu_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

@@ rtl/handheld_memory_map_unit.sv @@
// ----------------------------------------------------------------------------
// handheld_memory_map_unit
// Bus access unit over a 64 KiB byte store with region filtering, register
// side effects, echo aliasing and an object copy started by a register write.
// ----------------------------------------------------------------------------
//  channel  dir  tdata                          tuser
//  s_axis   in   [15:0] addr, [23:16] wdata     [1:0] func
//  m_axis   out  [15:0] rdata                   -
//
//  each byte read passes a read state and a capture state, set by the single
//  registered read port of the store; func 3 goes straight to a zero result.
//  an object copy write runs a read state and a write state per byte.
//  after reset a load pass writes the power-up contents of all 65536 bytes,
//  one byte a cycle; s_axis_tready_o stays low during it.
//  a new transaction is taken while the previous result waits on m_axis.
// ----------------------------------------------------------------------------
module handheld_memory_map_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [23:0] s_axis_tdata_i,  // [15:0] addr, [23:16] wdata
  input  logic [1:0]  s_axis_tuser_i,  // [1:0] func
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [15:0] m_axis_tdata_o   // [15:0] rdata
);
  import hmmu_pkg::*;

  state_e state_q, state_d;

  logic [1:0]           func_q, func_d;
  logic [ADDR_W-1:0]    addr_q, addr_d;
  logic [DATA_W-1:0]    wdata_q, wdata_d;
  logic [15:0]          res_q, res_d;
  logic [DATA_W-1:0]    frc_q, frc_d;
  logic [DMA_CNT_W-1:0] cnt_q, cnt_d;
  logic [ADDR_W-1:0]    clr_q, clr_d;
  logic                 out_valid_q, out_valid_d;
  logic [15:0]          out_data_q, out_data_d;

  logic                 ram_we;
  logic [ADDR_W-1:0]    ram_waddr;
  logic [DATA_W-1:0]    ram_wdata;
  logic [ADDR_W-1:0]    ram_raddr;
  logic [DATA_W-1:0]    ram_rdata;
  logic [DATA_W-1:0]    rd_byte;
  logic [ADDR_W-1:0]    hi_addr;
  logic [ADDR_W-1:0]    dma_src;
  logic                 in_fire;

  assign in_fire         = s_axis_tvalid_i && s_axis_tready_o;
  assign s_axis_tready_o = (state_q == S_IDLE);
  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_data_q;

  assign rd_byte = ram_rdata | frc_q;
  assign hi_addr = addr_q + 16'd1;
  assign dma_src = {wdata_q, 8'h00} | ADDR_W'(cnt_q);

  // byte store
  hmmu_ram #(
    .WIDTH (DATA_W),
    .DEPTH (MEM_DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // sequencer
  always_comb begin
    state_d     = state_q;
    func_d      = func_q;
    addr_d      = addr_q;
    wdata_d     = wdata_q;
    res_d       = res_q;
    frc_d       = frc_q;
    cnt_d       = cnt_q;
    clr_d       = clr_q;
    out_valid_d = out_valid_q;
    out_data_d  = out_data_q;
    ram_we      = 1'b0;
    ram_waddr   = map_addr(addr_q);
    ram_wdata   = wdata_q;
    ram_raddr   = map_addr(addr_q);

    // output register drains
    if (out_valid_q && m_axis_tready_i) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      S_CLR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_q;
        ram_wdata = init_value(clr_q);
        clr_d     = clr_q + 16'd1;
        if (clr_q == 16'hFFFF) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_fire) begin
          func_d  = s_axis_tuser_i;
          addr_d  = s_axis_tdata_i[15:0];
          wdata_d = s_axis_tdata_i[23:16];
          res_d   = '0;
          case (s_axis_tuser_i)
            FUNC_RD, FUNC_RD16: state_d = S_RD_LO;
            FUNC_WR:            state_d = S_WR;
            default:            state_d = S_DONE;
          endcase
        end
      end
      S_RD_LO: begin
        ram_raddr = map_addr(addr_q);
        frc_d     = force_mask(addr_q);
        state_d   = S_CAP_LO;
      end
      S_CAP_LO: begin
        res_d = {8'h00, rd_byte};
        if (func_q == FUNC_RD16) begin
          state_d = S_RD_HI;
        end else begin
          state_d = S_DONE;
        end
      end
      S_RD_HI: begin
        ram_raddr = map_addr(hi_addr);
        frc_d     = force_mask(hi_addr);
        state_d   = S_CAP_HI;
      end
      S_CAP_HI: begin
        res_d   = {rd_byte, res_q[7:0]};
        state_d = S_DONE;
      end
      S_WR: begin
        state_d = S_DONE;
        if (addr_q < ROM_END || addr_q inside {[UNUSE_BASE:UNUSE_LAST]}) begin
          ram_we = 1'b0;
        end else if (addr_q == DMA_ADDR) begin
          cnt_d   = '0;
          state_d = S_DMA_RD;
        end else begin
          ram_we    = 1'b1;
          ram_waddr = map_addr(addr_q);
          if (addr_q == JOYP_ADDR) begin
            ram_wdata = wdata_q & JOYP_WMASK;
          end else if (addr_q == DIV_ADDR || addr_q == LY_ADDR) begin
            ram_wdata = '0;
          end else begin
            ram_wdata = wdata_q;
          end
        end
      end
      S_DMA_RD: begin
        ram_raddr = map_addr(dma_src);
        frc_d     = force_mask(dma_src);
        state_d   = S_DMA_WR;
      end
      S_DMA_WR: begin
        ram_we    = 1'b1;
        ram_waddr = OAM_BASE + ADDR_W'(cnt_q);
        ram_wdata = rd_byte;
        if (cnt_q == DMA_CNT_W'(DMA_LEN - 1)) begin
          state_d = S_DONE;
        end else begin
          cnt_d   = cnt_q + 1'b1;
          state_d = S_DMA_RD;
        end
      end
      S_DONE: begin
        if (!out_valid_q || m_axis_tready_i) begin
          out_valid_d = 1'b1;
          out_data_d  = res_q;
          state_d     = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLR;
      clr_q       <= '0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    func_q     <= func_d;
    addr_q     <= addr_d;
    wdata_q    <= wdata_d;
    res_q      <= res_d;
    frc_q      <= frc_d;
    out_data_q <= out_data_d;
  end

  // no result leaves during the load pass
  a_no_out_in_clr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_CLR) |-> !m_axis_tvalid_o)
    else $error("result valid during load pass");

  // an accepted transaction starts work
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> (state_q != S_IDLE))
    else $error("sequencer stayed idle after accept");

  // object copy only writes the object area
  a_dma_dest: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ram_we && state_q == S_DMA_WR) |-> (ram_waddr[15:8] == 8'hFE))
    else $error("object copy outside object area");

  // rom area is never written after the load pass
  a_rom_protect: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ram_we && state_q != S_CLR) |-> ram_waddr[15])
    else $error("write reached rom area");

  // a new result is only loaded once the old one is taken
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !m_axis_tready_i) |=> (out_valid_q && $stable(out_data_q)))
    else $error("pending result overwritten");

endmodule

@@ tb/sv/hmmu_checker.sv @@
// ----------------------------------------------------------------------------
// hmmu_checker
// Watches both stream channels of the memory map unit. It keeps its own image
// of the 64 KiB store, works out the read value of every accepted access,
// and compares each returned word against the oldest outstanding prediction.
// ----------------------------------------------------------------------------
module hmmu_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  input  logic        s_axis_tready_i,
  input  logic [23:0] s_axis_tdata_i,  // [15:0] addr, [23:16] wdata
  input  logic [1:0]  s_axis_tuser_i,  // [1:0] func
  input  logic        m_axis_tvalid_i,
  input  logic        m_axis_tready_i,
  input  logic [15:0] m_axis_tdata_i,  // [15:0] rdata
  output int unsigned fail_count_o,
  output int unsigned pending_o
);
  import hmmu_pkg::*;

  // one outstanding read value, with the access that caused it
  typedef struct packed {
    logic [1:0]        func;
    logic [ADDR_W-1:0] addr;
    logic [15:0]       rdata;
  } access_word_t;

  logic [DATA_W-1:0] mem_img [MEM_DEPTH];
  access_word_t      rdata_due_q [$];

  initial fail_count_o = 0;
  assign pending_o = rdata_due_q.size();

  // power-up image of the store
  function automatic void load_powerup();
    foreach (mem_img[i]) mem_img[i] = '0;
    mem_img[16'hFF00] = 8'hFF;
    mem_img[16'hFF10] = 8'h80;
    mem_img[16'hFF11] = 8'hBF;
    mem_img[16'hFF12] = 8'hF3;
    mem_img[16'hFF14] = 8'hBF;
    mem_img[16'hFF16] = 8'h3F;
    mem_img[16'hFF19] = 8'hBF;
    mem_img[16'hFF1A] = 8'h7F;
    mem_img[16'hFF1B] = 8'hFF;
    mem_img[16'hFF1C] = 8'h9F;
    mem_img[16'hFF1E] = 8'hBF;
    mem_img[16'hFF20] = 8'hFF;
    mem_img[16'hFF23] = 8'hBF;
    mem_img[16'hFF24] = 8'h77;
    mem_img[16'hFF25] = 8'hF3;
    mem_img[16'hFF26] = 8'hF1;
    mem_img[16'hFF40] = 8'h91;
    mem_img[16'hFF47] = 8'hFC;
    mem_img[16'hFF48] = 8'hFF;
    mem_img[16'hFF49] = 8'hFF;
  endfunction

  // echo window aliases work ram
  function automatic logic [ADDR_W-1:0] fold_echo(input logic [ADDR_W-1:0] a);
    if (a >= ECHO_BASE && a <= ECHO_LAST) begin
      return a - ECHO_OFS;
    end
    return a;
  endfunction

  // bus read with forced register bits
  function automatic logic [DATA_W-1:0] peek_byte(input logic [ADDR_W-1:0] a);
    if (a == JOYP_ADDR) begin
      return mem_img[a] | JOYP_FORCE;
    end
    if (a == IF_ADDR) begin
      return mem_img[a] | IF_FORCE;
    end
    return mem_img[fold_echo(a)];
  endfunction

  // object copy from a source page into the object area, byte by byte
  function automatic void oam_copy(input logic [7:0] page);
    logic [ADDR_W-1:0] src;
    src = {page, 8'h00};
    for (int unsigned i = 0; i < DMA_LEN && i < 256; i++) begin
      mem_img[OAM_BASE + ADDR_W'(i)] = peek_byte(src + ADDR_W'(i));
    end
  endfunction

  // bus write with region filtering and register side effects
  function automatic void poke_byte(input logic [ADDR_W-1:0] a,
                                    input logic [DATA_W-1:0] d);
    if (a < ROM_END) begin
      return;
    end
    if (a >= UNUSE_BASE && a <= UNUSE_LAST) begin
      return;
    end
    if (a == JOYP_ADDR) begin
      mem_img[a] = d & JOYP_WMASK;
    end else if (a == DIV_ADDR || a == LY_ADDR) begin
      mem_img[a] = '0;
    end else if (a == DMA_ADDR) begin
      oam_copy(d);
    end else begin
      mem_img[fold_echo(a)] = d;
    end
  endfunction

  // read value of one access, applying its effect on the store image
  function automatic logic [15:0] access_rdata(input logic [1:0]        func,
                                               input logic [ADDR_W-1:0] addr,
                                               input logic [DATA_W-1:0] wdata);
    logic [15:0] r;
    r = '0;
    case (func)
      FUNC_RD:   r = {8'h00, peek_byte(addr)};
      FUNC_WR:   poke_byte(addr, wdata);
      FUNC_RD16: r = {peek_byte(addr + 16'd1), peek_byte(addr)};
      default:   r = '0;
    endcase
    return r;
  endfunction

  // watch both channels; results are retired before new accesses are queued
  always @(posedge clk_i or negedge rst_ni) begin
    access_word_t want;
    access_word_t got;
    if (!rst_ni) begin
      load_powerup();
      rdata_due_q.delete();
    end else begin
      if (m_axis_tvalid_i && m_axis_tready_i) begin
        if (rdata_due_q.size() == 0) begin
          $error("unexpected result transaction: rdata %h", m_axis_tdata_i);
          fail_count_o <= fail_count_o + 1;
        end else begin
          want = rdata_due_q.pop_front();
          if (m_axis_tdata_i !== want.rdata) begin
            $error("rdata mismatch (func %0d addr %h): expected %h, actual %h",
                   want.func, want.addr, want.rdata, m_axis_tdata_i);
            fail_count_o <= fail_count_o + 1;
          end
        end
      end
      if (s_axis_tvalid_i && s_axis_tready_i) begin
        got.func  = s_axis_tuser_i;
        got.addr  = s_axis_tdata_i[15:0];
        got.rdata = access_rdata(s_axis_tuser_i, s_axis_tdata_i[15:0],
                                 s_axis_tdata_i[23:16]);
        rdata_due_q.push_back(got);
      end
    end
  end

endmodule

@@ tb/sv/tb_top.sv @@
// ----------------------------------------------------------------------------
// tb_top
// Stimulus and verdict for the memory map unit. A directed run covers the
// register side effects, region filtering, echo aliasing, the object copy and
// the wrap of a 16-bit read at the top of memory; random accesses on a few
// busy address windows follow under three idling profiles. The checker
// beside the block predicts and compares every result.
// ----------------------------------------------------------------------------
module tb_top;
  import hmmu_pkg::*;

  // access kind that the block must treat as a no-op
  localparam logic [1:0] FUNC_NONE = 2'd3;
  localparam int unsigned RAND_PER_PHASE = 284;
  localparam int unsigned END_WAIT       = 400;

  logic        clk_i   = 1'b0;
  logic        rst_ni  = 1'b0;
  logic        s_valid = 1'b0;
  logic        s_ready;
  logic [23:0] s_data  = '0;
  logic [1:0]  s_user  = '0;
  logic        m_valid;
  logic        m_ready = 1'b0;
  logic [15:0] m_data;

  int unsigned tx_idle_pct = 0;
  int unsigned rx_idle_pct = 0;
  int unsigned fail_count;
  int unsigned pending;

  always #2 clk_i = ~clk_i;

  handheld_memory_map_unit DUT (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_valid),
    .s_axis_tready_o (s_ready),
    .s_axis_tdata_i  (s_data),
    .s_axis_tuser_i  (s_user),
    .m_axis_tvalid_o (m_valid),
    .m_axis_tready_i (m_ready),
    .m_axis_tdata_o  (m_data)
  );

  hmmu_checker u_checker (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_valid),
    .s_axis_tready_i (s_ready),
    .s_axis_tdata_i  (s_data),
    .s_axis_tuser_i  (s_user),
    .m_axis_tvalid_i (m_valid),
    .m_axis_tready_i (m_ready),
    .m_axis_tdata_i  (m_data),
    .fail_count_o    (fail_count),
    .pending_o       (pending)
  );

  // result side back-pressure
  always @(posedge clk_i) begin
    m_ready <= ($urandom_range(99) >= rx_idle_pct);
  end

  // one access transaction, with random idle cycles ahead of it
  task automatic issue_access(input logic [1:0] func, input logic [15:0] addr,
                              input logic [7:0] wdata);
    while ($urandom_range(99) < tx_idle_pct) begin
      s_valid <= 1'b0;
      @(posedge clk_i);
    end
    s_valid <= 1'b1;
    s_data  <= {wdata, addr};
    s_user  <= func;
    do @(posedge clk_i); while (!s_ready);
  endtask

  // hold off the sender until every outstanding result has come back
  task automatic drain_results();
    s_valid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
  endtask

  // addresses mostly land in a few small windows so reads see earlier writes
  function automatic logic [15:0] pick_addr();
    logic [15:0] base;
    case ($urandom_range(12))
      0:       base = 16'hC000;
      1:       base = 16'hDDF0;
      2:       base = 16'hE000;
      3:       base = 16'hFDF0;
      4:       base = OAM_BASE;
      5:       base = 16'hFE90;
      6:       base = JOYP_ADDR;
      7:       base = 16'hFF40;
      8:       base = 16'hFFE0;
      9:       base = ROM_END;
      10:      base = 16'h7FF0;
      11:      base = 16'h0000;
      default: return 16'($urandom);
    endcase
    return base + 16'($urandom_range(31));
  endfunction

  // copy source pages, biased toward ram, echo and the object area itself
  function automatic logic [7:0] pick_page();
    case ($urandom_range(7))
      0:       return 8'hC0;
      1:       return 8'hDD;
      2:       return 8'hE0;
      3:       return 8'hFD;
      4:       return 8'hFE;
      5:       return 8'hFF;
      6:       return 8'h80;
      default: return 8'($urandom_range(255));
    endcase
  endfunction

  // one random access
  task automatic random_access();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 4) begin
      issue_access(FUNC_WR, DMA_ADDR, pick_page());
    end else if (r < 40) begin
      issue_access(FUNC_WR, pick_addr(), 8'($urandom));
    end else if (r < 65) begin
      issue_access(FUNC_RD, pick_addr(), 8'($urandom));
    end else if (r < 95) begin
      issue_access(FUNC_RD16, pick_addr(), 8'($urandom));
    end else begin
      issue_access(FUNC_NONE, 16'($urandom), 8'($urandom));
    end
  endtask

  // run limit
  initial begin
    #8_000_000;
    $display("*** FAILED ***");
    $finish;
  end

  initial begin
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed: joypad and interrupt flag forcing
    issue_access(FUNC_RD,   JOYP_ADDR, 8'h00);
    issue_access(FUNC_WR,   JOYP_ADDR, 8'h5A);
    issue_access(FUNC_RD,   JOYP_ADDR, 8'h00);
    issue_access(FUNC_RD,   IF_ADDR,   8'h00);
    issue_access(FUNC_WR,   IF_ADDR,   8'h1F);
    issue_access(FUNC_RD16, 16'hFF0E,  8'h00);
    // divider and line counter clear on write
    issue_access(FUNC_WR,   DIV_ADDR,  8'hAB);
    issue_access(FUNC_RD,   DIV_ADDR,  8'h00);
    issue_access(FUNC_WR,   LY_ADDR,   8'hFF);
    issue_access(FUNC_RD16, 16'hFF43,  8'h00);
    // rom and unusable area drop writes
    issue_access(FUNC_WR,   16'h7FFF,  8'h55);
    issue_access(FUNC_WR,   ROM_END,   8'hFF);
    issue_access(FUNC_RD16, 16'h7FFF,  8'h00);
    issue_access(FUNC_WR,   UNUSE_BASE, 8'h11);
    issue_access(FUNC_WR,   UNUSE_LAST, 8'h22);
    issue_access(FUNC_RD16, UNUSE_LAST, 8'h00);
    // echo aliasing both ways
    issue_access(FUNC_WR,   16'hC000,  8'hA5);
    issue_access(FUNC_WR,   ECHO_LAST, 8'h3C);
    issue_access(FUNC_RD16, ECHO_BASE, 8'h00);
    issue_access(FUNC_RD16, 16'hDDFE,  8'h00);
    // object copy from work ram, then from the object area onto itself
    issue_access(FUNC_WR,   DMA_ADDR,  8'hC0);
    issue_access(FUNC_RD16, OAM_BASE,  8'h00);
    issue_access(FUNC_WR,   DMA_ADDR,  8'hFE);
    issue_access(FUNC_RD,   DMA_ADDR,  8'h00);
    // 16-bit read wrapping past the top of memory
    issue_access(FUNC_WR,   16'hFFFF,  8'h80);
    issue_access(FUNC_RD16, 16'hFFFF,  8'h00);
    // unused access kind
    issue_access(FUNC_NONE, 16'hFFFF,  8'hFF);

    // random phases: receiver idles more, then sender, then neither
    drain_results();
    tx_idle_pct = 14;
    rx_idle_pct = 53;
    repeat (RAND_PER_PHASE) random_access();
    drain_results();
    tx_idle_pct = 53;
    rx_idle_pct = 14;
    repeat (RAND_PER_PHASE) random_access();
    drain_results();
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    repeat (RAND_PER_PHASE) random_access();
    drain_results();

    repeat (END_WAIT) @(posedge clk_i);
    if (fail_count == 0 && pending == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
